>>> src/sobel_gradient_magnitude_unit_assert.svh
// Assertion macros for the Sobel gradient magnitude unit.
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SGM_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("sgm invariant violated");

// A condition that must hold in the cycle after a trigger.
`define SGM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sgm sequence violated");

`endif

>>> src/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude unit.
package sgm_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 11;
    localparam int SIZE_W     = 12;
    localparam int ROOT_W     = 16;
    localparam int ROOT_STEPS = 8;

    localparam logic [ROOT_W-1:0] ROOT_TRIAL_FIRST = 16'h4000;
    localparam logic [PIX_W-1:0]  MAG_LIMIT        = 8'd255;
    localparam logic [20:0]       SQ_LIMIT         = 21'd65025;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic             zero;
        logic             sat;
    } meta_t;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        meta_t             meta;
    } root_t;

endpackage

>>> src/sgm_ram.sv
// Generic simple dual-port RAM with a registered read port.
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sgm_root_cell.sv
// One cell of the square root chain: resolves one result bit per stage.
module sgm_root_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  sgm_pkg::root_t in_data,
    output sgm_pkg::root_t out_data
);

    import sgm_pkg::*;

    root_t           out_reg;
    root_t           out_next;
    logic [ROOT_W:0] trial_sum;
    logic            take;

    always_comb begin
        trial_sum = {1'b0, in_data.root} + {1'b0, in_data.trial};
        take      = {1'b0, in_data.rem} >= trial_sum;
        out_next       = in_data;
        out_next.trial = in_data.trial >> 2;
        if (take) begin
            out_next.rem  = in_data.rem - trial_sum[ROOT_W-1:0];
            out_next.root = (in_data.root >> 1) + in_data.trial;
        end else begin
            out_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= out_next.valid;
        end
        if (en) begin
            out_reg.rem   <= out_next.rem;
            out_reg.root  <= out_next.root;
            out_reg.trial <= out_next.trial;
            out_reg.meta  <= out_next.meta;
        end
    end

    assign out_data = out_reg;

endmodule

>>> src/sobel_gradient_magnitude_unit.sv
// Top level of the streaming 3x3 Sobel gradient magnitude unit.
// Accepts one request per cycle while s_ready is high; s_ready drops while the skid stage holds a result.
// Results trail the pixel stream by one row plus one pixel in raster order.
// The pipeline runs line-store read, window, kernel sums, squares and an 8-cell root chain.
// Reset clears counters, window and pipeline and sets the frame to 640 (at most MAX_WIDTH) by 480.
// The line stores are not cleared; their unwritten entries only reach border results.
module sobel_gradient_magnitude_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [sgm_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [sgm_pkg::PIX_W-1:0]   s_pixel_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sgm_pkg::PIX_W-1:0]   m_magnitude,
    output logic [sgm_pkg::POS_W-1:0]   m_result_row,
    output logic [sgm_pkg::POS_W-1:0]   m_result_col,
    output logic                        m_frame_last
);

    import sgm_pkg::*;

    `include "sobel_gradient_magnitude_unit_assert.svh"

    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_CAP = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int HEIGHT_CAP = 2048;
    localparam int WIDTH_RST = (640 > WIDTH_CAP) ? WIDTH_CAP : 640;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_W'(3)) begin
            r = SIZE_W'(3);
        end else if (v > cap) begin
            r = cap;
        end
        return r;
    endfunction

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [POS_W-1:0]  in_row_reg;
    logic [POS_W-1:0]  in_col_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [SIZE_W-1:0] pend_reg;
    logic              skid_valid_reg;

    logic en;
    logic accept;
    logic is_pix;
    logic emit;
    logic border;
    logic frame_end;
    logic in_col_wrap;
    logic out_col_wrap;
    meta_t acc_meta;

    assign en     = !skid_valid_reg;
    assign accept = s_valid && s_ready;
    assign is_pix = (s_operation == OP_PIXEL);
    assign emit   = is_pix ? (pend_reg == width_reg + SIZE_W'(1)) : (pend_reg != '0);

    assign border = (out_row_reg == '0) || (out_col_reg == '0)
                 || ({1'b0, out_row_reg} + SIZE_W'(1) >= height_reg)
                 || ({1'b0, out_col_reg} + SIZE_W'(1) >= width_reg);
    assign frame_end = ({1'b0, out_row_reg} + SIZE_W'(1) == height_reg)
                    && ({1'b0, out_col_reg} + SIZE_W'(1) == width_reg);
    assign in_col_wrap  = ({1'b0, in_col_reg} + SIZE_W'(1) >= width_reg);
    assign out_col_wrap = ({1'b0, out_col_reg} + SIZE_W'(1) >= width_reg);

    always_comb begin
        acc_meta.row  = out_row_reg;
        acc_meta.col  = out_col_reg;
        acc_meta.last = frame_end;
        acc_meta.zero = !is_pix || border;
        acc_meta.sat  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= SIZE_W'(WIDTH_RST);
            height_reg  <= SIZE_W'(480);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                width_reg <= clamp_size(cfg_wr_data, SIZE_W'(WIDTH_CAP));
            end else begin
                height_reg <= clamp_size(cfg_wr_data, SIZE_W'(HEIGHT_CAP));
            end
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
        end else if (accept) begin
            if (is_pix) begin
                if (in_col_wrap) begin
                    in_col_reg <= '0;
                    if ({1'b0, in_row_reg} + SIZE_W'(1) >= height_reg) begin
                        in_row_reg <= '0;
                    end else begin
                        in_row_reg <= in_row_reg + POS_W'(1);
                    end
                end else begin
                    in_col_reg <= in_col_reg + POS_W'(1);
                end
                if (!emit) begin
                    pend_reg <= pend_reg + SIZE_W'(1);
                end
            end else if (emit) begin
                pend_reg <= pend_reg - SIZE_W'(1);
            end
            if (emit) begin
                if (out_col_wrap) begin
                    out_col_reg <= '0;
                    if ({1'b0, out_row_reg} + SIZE_W'(1) >= height_reg) begin
                        out_row_reg <= '0;
                    end else begin
                        out_row_reg <= out_row_reg + POS_W'(1);
                    end
                end else begin
                    out_col_reg <= out_col_reg + POS_W'(1);
                end
            end
        end
    end

    // Stage 1: line-store read data arrives; stores are rewritten for this column.
    logic              p1_valid_reg;
    logic              p1_pix_reg;
    logic              p1_emit_reg;
    logic [PIX_W-1:0]  p1_bot_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    meta_t             p1_meta_reg;
    logic [PIX_W-1:0]  top_data;
    logic [PIX_W-1:0]  mid_data;
    logic              store_wr;

    assign store_wr = en && p1_valid_reg && p1_pix_reg;

    sgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk     (aclk),
        .wr_en   (store_wr),
        .wr_addr (p1_addr_reg),
        .wr_data (p1_bot_reg),
        .rd_en   (accept && is_pix),
        .rd_addr (ADDR_W'(in_col_reg)),
        .rd_data (mid_data)
    );

    sgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk     (aclk),
        .wr_en   (store_wr),
        .wr_addr (p1_addr_reg),
        .wr_data (mid_data),
        .rd_en   (accept && is_pix),
        .rd_addr (ADDR_W'(in_col_reg)),
        .rd_data (top_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= accept && (is_pix || emit);
        end
        if (en) begin
            p1_pix_reg  <= is_pix;
            p1_emit_reg <= emit;
            p1_bot_reg  <= s_pixel_value;
            p1_addr_reg <= ADDR_W'(in_col_reg);
            p1_meta_reg <= acc_meta;
        end
    end

    // Stage 2: the 3x3 window after this pixel's shift.
    logic [PIX_W-1:0] window_reg [9];
    logic             p2_valid_reg;
    meta_t            p2_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                window_reg[i] <= '0;
            end
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
            if (p1_valid_reg && p1_pix_reg) begin
                for (int r = 0; r < 3; r++) begin
                    window_reg[r*3]   <= window_reg[r*3+1];
                    window_reg[r*3+1] <= window_reg[r*3+2];
                end
                window_reg[2] <= top_data;
                window_reg[5] <= mid_data;
                window_reg[8] <= p1_bot_reg;
            end
        end
        if (en) begin
            p2_meta_reg <= p1_meta_reg;
        end
    end

    // Stage 3: kernel sums.
    logic signed [10:0] w [9];
    logic signed [10:0] g1;
    logic signed [10:0] g2;
    logic signed [10:0] g1_reg;
    logic signed [10:0] g2_reg;
    logic               p3_valid_reg;
    meta_t              p3_meta_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w[i] = $signed({3'b000, window_reg[i]});
        end
        g1 = (w[0] + (w[1] <<< 1) + w[2]) - (w[6] + (w[7] <<< 1) + w[8]);
        g2 = (w[0] + (w[3] <<< 1) + w[6]) - (w[2] + (w[5] <<< 1) + w[8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
        if (en) begin
            g1_reg      <= g1;
            g2_reg      <= g2;
            p3_meta_reg <= p2_meta_reg;
        end
    end

    // Stage 4: squares.
    logic signed [21:0] prod1;
    logic signed [21:0] prod2;
    logic [19:0]        sq1_reg;
    logic [19:0]        sq2_reg;
    logic               p4_valid_reg;
    meta_t              p4_meta_reg;

    assign prod1 = g1_reg * g1_reg;
    assign prod2 = g2_reg * g2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= p3_valid_reg;
        end
        if (en) begin
            sq1_reg     <= prod1[19:0];
            sq2_reg     <= prod2[19:0];
            p4_meta_reg <= p3_meta_reg;
        end
    end

    // Root chain.
    logic [20:0] sq_sum;
    root_t       link [ROOT_STEPS+1];

    assign sq_sum = {1'b0, sq1_reg} + {1'b0, sq2_reg};

    always_comb begin
        link[0].valid    = p4_valid_reg;
        link[0].rem      = sq_sum[ROOT_W-1:0];
        link[0].root     = '0;
        link[0].trial    = ROOT_TRIAL_FIRST;
        link[0].meta     = p4_meta_reg;
        link[0].meta.sat = (sq_sum >= SQ_LIMIT);
    end

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        sgm_root_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_data  (link[k]),
            .out_data (link[k+1])
        );
    end

    // Output register with a one-entry skid stage.
    logic [PIX_W-1:0] fin_mag;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_mag_reg;
    logic [POS_W-1:0] out_res_row_reg;
    logic [POS_W-1:0] out_res_col_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] skid_mag_reg;
    logic [POS_W-1:0] skid_row_reg;
    logic [POS_W-1:0] skid_col_reg;
    logic             skid_last_reg;
    root_t            fin;

    assign fin = link[ROOT_STEPS];
    assign fin_mag = fin.meta.zero ? '0 : (fin.meta.sat ? MAG_LIMIT : fin.root[PIX_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (fin.valid) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_ready) begin
            skid_valid_reg <= 1'b0;
        end
        if (en) begin
            if (!out_valid_reg || m_ready) begin
                out_mag_reg     <= fin_mag;
                out_res_row_reg <= fin.meta.row;
                out_res_col_reg <= fin.meta.col;
                out_last_reg    <= fin.meta.last;
            end else begin
                skid_mag_reg  <= fin_mag;
                skid_row_reg  <= fin.meta.row;
                skid_col_reg  <= fin.meta.col;
                skid_last_reg <= fin.meta.last;
            end
        end else if (m_ready) begin
            out_mag_reg     <= skid_mag_reg;
            out_res_row_reg <= skid_row_reg;
            out_res_col_reg <= skid_col_reg;
            out_last_reg    <= skid_last_reg;
        end
    end

    assign s_ready      = en;
    assign m_valid      = out_valid_reg;
    assign m_magnitude  = out_mag_reg;
    assign m_result_row = out_res_row_reg;
    assign m_result_col = out_res_col_reg;
    assign m_frame_last = out_last_reg;

    `SGM_ASSERT_ALWAYS(a_skid_needs_out, aclk, aresetn, !skid_valid_reg || out_valid_reg)
    `SGM_ASSERT_ALWAYS(a_pend_bound, aclk, aresetn, pend_reg <= width_reg + SIZE_W'(1))
    `SGM_ASSERT_ALWAYS(a_col_bound, aclk, aresetn, {1'b0, in_col_reg} < width_reg)
    `SGM_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_ready, !skid_valid_reg)

endmodule
